### rtl/brue_pkg.sv
// ----------------------------------------------------------------------------
// brue_pkg - shared types and constants for the bitset range update engine
// Command codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package brue_pkg;

    localparam int WORD_BITS      = 64;
    localparam int POS_BITS       = 6;
    localparam int IDX_W          = 12;
    localparam int WIDX_W         = IDX_W - POS_BITS;
    localparam int CMP_W          = 13;   // holds any word count up to 4096
    localparam int DEF_WORD_COUNT = 64;

    typedef enum logic [2:0] {
        FN_READ     = 3'd0,
        FN_SET      = 3'd1,
        FN_CLR      = 3'd2,
        FN_FLIP     = 3'd3,
        FN_SET_RNG  = 3'd4,
        FN_CLR_RNG  = 3'd5,
        FN_FLIP_RNG = 3'd6,
        FN_ASSIGN   = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        OP_SET  = 2'd1,
        OP_CLR  = 2'd2,
        OP_FLIP = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIT_RD,
        ST_BIT_OUT,
        ST_RMW,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic load;        // capture request fields
        logic rd_bit;      // read word for a bit query
        logic rmw_step;    // read one word of a modify pass
        logic sweep_step;  // write one word of a fill pass
        logic sweep_val;   // word 0 of the fill pass takes the request value
        logic out_load;    // capture result bit
    } cmd_t;

    typedef struct packed {
        logic skip;        // nothing to touch (reversed range or beyond store)
        logic rmw_last;    // pointer sits on the last word of the pass
        logic sweep_last;  // pointer sits on the top word of the store
    } stat_t;

endpackage

### rtl/brue_ctrl.sv
// ----------------------------------------------------------------------------
// brue_ctrl - sequencer for the bitset range update engine
// Dispatches requests, steps word passes and owns the handshakes.
// ----------------------------------------------------------------------------
module brue_ctrl
    import brue_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  func_t func,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority case (func)
                        FN_READ:   state_next = ST_BIT_RD;
                        FN_ASSIGN: state_next = ST_SWEEP;
                        default:   state_next = ST_RMW;
                    endcase
                end
            end
            ST_BIT_RD:
                state_next = ST_BIT_OUT;
            ST_BIT_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            ST_RMW:
            begin
                if (stat.skip || stat.rmw_last)
                    state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (stat.sweep_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
                cmd.sweep_step = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // in_ready is high here, so a valid request is taken
                cmd.load = in_valid;
            end
            ST_BIT_RD:
                cmd.rd_bit = 1'b1;
            ST_BIT_OUT:
                cmd.out_load = !out_valid_reg || out_ready;
            ST_RMW:
                cmd.rmw_step = !stat.skip;
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_val  = 1'b1;
            end
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/brue_dpath.sv
// ----------------------------------------------------------------------------
// brue_dpath - word store and update datapath
// Word memory, request registers, edge masks and the read-modify-write stage.
// ----------------------------------------------------------------------------
module brue_dpath
    import brue_pkg::*;
#(
    parameter int WORD_COUNT = DEF_WORD_COUNT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic [2:0]           func,
    input  logic [IDX_W-1:0]     low_index,
    input  logic [IDX_W-1:0]     high_index,
    input  logic [WORD_BITS-1:0] value,
    output logic                 bit_value
);

    localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [AW-1:0]    TOP_ADDR = AW'(WORD_COUNT - 1);
    localparam logic [CMP_W-1:0] TOP_CMP  = CMP_W'(WORD_COUNT - 1);

    // bits lo..hi set
    function automatic logic [WORD_BITS-1:0] span_mask(
        input logic [POS_BITS-1:0] lo,
        input logic [POS_BITS-1:0] hi
    );
        logic [WORD_BITS-1:0] ones;
        ones = '1;
        return (ones << lo) & (ones >> (POS_BITS'(WORD_BITS - 1) - hi));
    endfunction

    logic [WORD_BITS-1:0] mem [WORD_COUNT];

    op_t                   op_reg, op_next;
    logic [WIDX_W-1:0]     wl_reg, wh_reg, wh_next;
    logic [POS_BITS-1:0]   pl_reg, ph_reg, ph_next;
    logic [WORD_BITS-1:0]  value_reg;
    logic                  skip_reg, skip_next;
    logic [AW-1:0]         last_reg, last_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         wr_ptr_reg;
    logic                  wr_pend_reg;
    logic [WORD_BITS-1:0]  rdata_reg;
    logic                  bit_reg;
    logic [WORD_BITS-1:0]  mask;
    logic [WORD_BITS-1:0]  rmw_data;
    logic [WORD_BITS-1:0]  sweep_data;
    logic [WIDX_W-1:0]     in_wl;
    logic                  is_range;

    assign in_wl    = low_index[IDX_W-1:POS_BITS];
    assign is_range = (func == FN_SET_RNG) || (func == FN_CLR_RNG) || (func == FN_FLIP_RNG);

    // request decode at accept
    always_comb
    begin
        unique case (func)
            FN_SET,  FN_SET_RNG:  op_next = OP_SET;
            FN_CLR,  FN_CLR_RNG:  op_next = OP_CLR;
            default:              op_next = OP_FLIP;
        endcase
        if (is_range)
        begin
            wh_next = high_index[IDX_W-1:POS_BITS];
            ph_next = high_index[POS_BITS-1:0];
        end
        else
        begin
            wh_next = in_wl;
            ph_next = low_index[POS_BITS-1:0];
        end
        skip_next = (CMP_W'(in_wl) > TOP_CMP) || (is_range && (low_index > high_index));
        if (CMP_W'(wh_next) > TOP_CMP)
            last_next = TOP_ADDR;
        else
            last_next = AW'(CMP_W'(wh_next));
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
            ptr_next = (func == FN_ASSIGN) ? '0 : AW'(CMP_W'(in_wl));
        else if (cmd.rmw_step || cmd.sweep_step)
            ptr_next = ptr_reg + AW'(1);
    end

    // request fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_next;
            wl_reg    <= in_wl;
            pl_reg    <= low_index[POS_BITS-1:0];
            wh_reg    <= wh_next;
            ph_reg    <= ph_next;
            value_reg <= value;
            skip_reg  <= skip_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            wr_pend_reg <= cmd.rmw_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rmw_step)
            wr_ptr_reg <= ptr_reg;
    end

    // edge words get partial masks, inner words full
    always_comb
    begin
        logic [POS_BITS-1:0] a, b;
        a = (CMP_W'(wr_ptr_reg) == CMP_W'(wl_reg)) ? pl_reg : '0;
        b = (CMP_W'(wr_ptr_reg) == CMP_W'(wh_reg)) ? ph_reg : POS_BITS'(WORD_BITS - 1);
        mask = span_mask(a, b);
    end

    always_comb
    begin
        unique case (op_reg)
            OP_SET:  rmw_data = rdata_reg | mask;
            OP_CLR:  rmw_data = rdata_reg & ~mask;
            OP_FLIP: rmw_data = rdata_reg ^ mask;
            default: rmw_data = rdata_reg;
        endcase
    end

    assign sweep_data = (cmd.sweep_val && (ptr_reg == '0)) ? value_reg : '0;

    // word memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
            mem[wr_ptr_reg] <= rmw_data;
        else if (cmd.sweep_step)
            mem[ptr_reg] <= sweep_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_bit || cmd.rmw_step)
            rdata_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            bit_reg <= !skip_reg && rdata_reg[pl_reg];
    end

    assign bit_value       = bit_reg;
    assign stat.skip       = skip_reg;
    assign stat.rmw_last   = (ptr_reg == last_reg);
    assign stat.sweep_last = (ptr_reg == TOP_ADDR);

endmodule

### rtl/bitset_range_update_engine_core.sv
// ----------------------------------------------------------------------------
// bitset_range_update_engine_core - bit store with bit and range commands
// Top level: sequencer plus word-memory datapath.
// ----------------------------------------------------------------------------
// The store holds WORD_COUNT words of 64 bits; bit n sits in word n/64 at
// position n%64. One request is taken at a time and in_ready is high only
// while the engine idles. Each word update is a read-modify-write through the
// single-write-port word memory, pipelined so one word is finished per cycle;
// that memory port sets the rate. A range command updates each word it
// touches (up to 64 at the default size); a reversed or out-of-store range
// touches none; assign rewrites every word. A read bit waits while an
// earlier result still waits for out_ready. After reset the store is zeroed
// by a clearing pass during which no request is taken. A read result sits
// in an output register, so requests are taken while it waits for out_ready.
// Indexes at or above 64*WORD_COUNT read as 0 and are never written.
// ----------------------------------------------------------------------------
module bitset_range_update_engine_core
    import brue_pkg::*;
#(
    parameter int WORD_COUNT = DEF_WORD_COUNT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           func,
    input  logic [IDX_W-1:0]     low_index,
    input  logic [IDX_W-1:0]     high_index,
    input  logic [WORD_BITS-1:0] value,
    // result channel (read bit only)
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 bit_value
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: dispatch, word pass stepping, handshakes
    brue_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func_t'(func)),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // word memory, masks and result bit
    brue_dpath #(
        .WORD_COUNT (WORD_COUNT)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .func       (func),
        .low_index  (low_index),
        .high_index (high_index),
        .value      (value),
        .bit_value  (bit_value)
    );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for bitset_range_update_engine_core
// Drives bit, range and assign requests through the valid/ready request
// channel, mirrors the word store in a local model and checks every read
// result bit in order. A short directed table comes first, then random
// traffic with random idles and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import brue_pkg::*;

    localparam int N_WORDS   = DEF_WORD_COUNT;
    localparam int N_RANDOM  = 900;
    localparam int TAIL_WAIT = 80;

    typedef struct packed {
        func_t                fn;
        logic [IDX_W-1:0]     lo;
        logic [IDX_W-1:0]     hi;
        logic [WORD_BITS-1:0] val;
        logic                 typed;    // expected bit given in the row
        logic                 exp_bit;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [2:0]           func = FN_READ;
    logic [IDX_W-1:0]     low_index = '0;
    logic [IDX_W-1:0]     high_index = '0;
    logic [WORD_BITS-1:0] value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 bit_value;

    // local copy of the word store and the read bits still owed by the block
    logic [WORD_BITS-1:0] bit_store [N_WORDS];
    logic                 pending_bits [$];
    stim_row_t            directed_rows [$];

    logic quiet = 1'b0;          // no idling on either side while set
    logic front_bit;
    int   n_mismatch = 0;
    int   n_results  = 0;
    int   n_directed = 0;
    int   n_random   = 0;
    int   n_ranges   = 0;

    bitset_range_update_engine_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .low_index  (low_index),
        .high_index (high_index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bit_value  (bit_value)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d read results still owed", $time, pending_bits.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // bits a..b of one word set
    function automatic logic [WORD_BITS-1:0] span_bits(input int a, input int b);
        logic [WORD_BITS-1:0] upper;
        if (b >= WORD_BITS - 1)
            upper = '1;
        else
            upper = (64'd1 << (b + 1)) - 64'd1;
        return upper & ~((64'd1 << a) - 64'd1);
    endfunction

    // apply one request to the local store; a read returns its bit
    task automatic update_bit_store(input func_t fn, input logic [IDX_W-1:0] lo,
                                    input logic [IDX_W-1:0] hi,
                                    input logic [WORD_BITS-1:0] val,
                                    output logic is_read, output logic rd_bit);
        int                   wl;
        int                   wh;
        int                   pl;
        int                   ph;
        logic [WORD_BITS-1:0] m;
        wl = lo >> POS_BITS;
        pl = lo % WORD_BITS;
        wh = hi >> POS_BITS;
        ph = hi % WORD_BITS;
        is_read = 1'b0;
        rd_bit  = 1'b0;
        case (fn)
            FN_READ:
            begin
                is_read = 1'b1;
                if (wl < N_WORDS)
                    rd_bit = bit_store[wl][pl];
            end
            FN_SET:  if (wl < N_WORDS) bit_store[wl][pl] = 1'b1;
            FN_CLR:  if (wl < N_WORDS) bit_store[wl][pl] = 1'b0;
            FN_FLIP: if (wl < N_WORDS) bit_store[wl][pl] = ~bit_store[wl][pl];
            FN_SET_RNG, FN_CLR_RNG, FN_FLIP_RNG:
            begin
                // reversed range leaves the store alone
                if (lo <= hi)
                begin
                    for (int w = wl; w <= wh && w < N_WORDS; w++)
                    begin
                        m = span_bits((w == wl) ? pl : 0, (w == wh) ? ph : WORD_BITS - 1);
                        if (fn == FN_SET_RNG)
                            bit_store[w] = bit_store[w] | m;
                        else if (fn == FN_CLR_RNG)
                            bit_store[w] = bit_store[w] & ~m;
                        else
                            bit_store[w] = bit_store[w] ^ m;
                    end
                end
            end
            default:
            begin
                for (int w = 0; w < N_WORDS; w++)
                    bit_store[w] = '0;
                bit_store[0] = val;
            end
        endcase
    endtask

    task automatic add_row(input func_t fn, input logic [IDX_W-1:0] lo,
                           input logic [IDX_W-1:0] hi, input logic [WORD_BITS-1:0] val,
                           input logic typed, input logic exp_bit);
        stim_row_t row;
        row = '{fn, lo, hi, val, typed, exp_bit};
        directed_rows.push_back(row);
    endtask

    // present one request, hold it until taken, then update the model
    task automatic send_request(input func_t fn, input logic [IDX_W-1:0] lo,
                                input logic [IDX_W-1:0] hi,
                                input logic [WORD_BITS-1:0] val,
                                input logic typed, input logic exp_bit);
        logic is_read;
        logic rd_bit;
        while (!quiet && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= fn;
        low_index  <= lo;
        high_index <= hi;
        value      <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        update_bit_store(fn, lo, hi, val, is_read, rd_bit);
        if (is_read)
            pending_bits.push_back(typed ? exp_bit : rd_bit);
        if (fn inside {FN_SET_RNG, FN_CLR_RNG, FN_FLIP_RNG})
            n_ranges++;
    endtask

    task automatic send_random();
        func_t                fn;
        logic [IDX_W-1:0]     lo;
        logic [IDX_W-1:0]     hi;
        logic [WORD_BITS-1:0] val;
        int                   r;
        int                   top;
        r   = $urandom_range(0, 99);
        lo  = IDX_W'($urandom_range(0, 4095));
        hi  = IDX_W'($urandom_range(0, 4095));   // don't-care for most commands
        val = {$urandom, $urandom};
        if (r < 38)
            fn = FN_READ;
        else if (r < 62)
        begin
            case ($urandom_range(0, 2))
                0:       fn = FN_SET;
                1:       fn = FN_CLR;
                default: fn = FN_FLIP;
            endcase
        end
        else if (r < 96)
        begin
            case ($urandom_range(0, 2))
                0:       fn = FN_SET_RNG;
                1:       fn = FN_CLR_RNG;
                default: fn = FN_FLIP_RNG;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    // short range, often inside one word or across a boundary
                    top = lo + $urandom_range(0, 150);
                    hi  = (top > 4095) ? 12'd4095 : top[IDX_W-1:0];
                end
                6, 7: ;                      // fully random ends, may be reversed
                8:
                begin
                    if (lo == hi)
                        lo = hi + 12'd1;
                    if (lo < hi)
                        {lo, hi} = {hi, lo};
                end
                default:
                begin
                    lo = IDX_W'($urandom_range(0, 70));
                    hi = IDX_W'(4095 - $urandom_range(0, 70));
                end
            endcase
        end
        else
            fn = FN_ASSIGN;
        send_request(fn, lo, hi, val, 1'b0, 1'b0);
    endtask

    // result side stalls at random except during the quiet stretch
    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(0, 99) >= 32);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bits.size() == 0)
            begin
                $display("%0t: bit_value %0b with no read pending", $time, bit_value);
                n_mismatch++;
            end
            else
            begin
                front_bit = pending_bits.pop_front();
                n_results++;
                if (bit_value !== front_bit)
                begin
                    $display("%0t: bit_value mismatch, expected %0b, got %0b",
                             $time, front_bit, bit_value);
                    n_mismatch++;
                end
            end
        end
    end

    initial
    begin
        for (int w = 0; w < N_WORDS; w++)
            bit_store[w] = '0;

        // fresh store, index extremes, each command, boundary-crossing and
        // reversed ranges, and assign wiping the upper words
        add_row(FN_READ,     12'd0,    12'd0,    '0, 1'b1, 1'b0);
        add_row(FN_READ,     12'd4095, 12'd4095, '1, 1'b1, 1'b0);
        add_row(FN_SET,      12'd4095, 12'd0,    '0, 1'b0, 1'b0);
        add_row(FN_READ,     12'd4095, 12'd0,    '0, 1'b1, 1'b1);
        add_row(FN_SET,      12'd0,    12'd4095, '1, 1'b0, 1'b0);
        add_row(FN_READ,     12'd0,    12'd0,    '0, 1'b1, 1'b1);
        add_row(FN_FLIP,     12'd0,    12'd0,    '0, 1'b0, 1'b0);
        add_row(FN_READ,     12'd0,    12'd0,    '0, 1'b1, 1'b0);
        add_row(FN_CLR,      12'd4095, 12'd0,    '0, 1'b0, 1'b0);
        add_row(FN_READ,     12'd4095, 12'd0,    '0, 1'b1, 1'b0);
        add_row(FN_SET_RNG,  12'd0,    12'd4095, '0, 1'b0, 1'b0);
        add_row(FN_READ,     12'd2000, 12'd0,    '0, 1'b1, 1'b1);
        add_row(FN_CLR_RNG,  12'd63,   12'd64,   '0, 1'b0, 1'b0);
        add_row(FN_READ,     12'd63,   12'd0,    '0, 1'b1, 1'b0);
        add_row(FN_READ,     12'd65,   12'd0,    '0, 1'b1, 1'b1);
        add_row(FN_FLIP_RNG, 12'd100,  12'd50,   '0, 1'b0, 1'b0);
        add_row(FN_READ,     12'd100,  12'd0,    '0, 1'b1, 1'b1);
        add_row(FN_FLIP_RNG, 12'd130,  12'd190,  '0, 1'b0, 1'b0);
        add_row(FN_READ,     12'd150,  12'd0,    '0, 1'b0, 1'b0);
        add_row(FN_ASSIGN,   12'd0,    12'd0,    64'h8000_0000_0000_0001, 1'b0, 1'b0);
        add_row(FN_READ,     12'd63,   12'd0,    '0, 1'b1, 1'b1);
        add_row(FN_READ,     12'd0,    12'd0,    '0, 1'b1, 1'b1);
        add_row(FN_READ,     12'd64,   12'd0,    '0, 1'b1, 1'b0);
        add_row(FN_ASSIGN,   12'd4095, 12'd4095, '1, 1'b0, 1'b0);
        add_row(FN_READ,     12'd62,   12'd0,    '0, 1'b1, 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].fn, directed_rows[i].lo, directed_rows[i].hi,
                         directed_rows[i].val, directed_rows[i].typed,
                         directed_rows[i].exp_bit);
            n_directed++;
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 450)
            begin
                // let every owed read result come back before going on
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_bits.size() != 0)
                    @(posedge clk);
            end
            quiet = (i >= 600 && i < 750);
            send_random();
            n_random++;
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (pending_bits.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Sent %0d requests (%0d table rows, %0d random, %0d ranges)",
                 n_directed + n_random, n_directed, n_random, n_ranges);
        $display("Checked %0d read results, %0d mismatches", n_results, n_mismatch);
        if (n_mismatch == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/brue_pkg.sv
rtl/brue_ctrl.sv
rtl/brue_dpath.sv
rtl/bitset_range_update_engine_core.sv
verif/tb.sv
